// ----- design/ppt_pkg.sv -----
// ----------------------------------------------------------------------------
// ppt_pkg
// Types, codes and helper functions shared by the prescaled period timer.
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

    localparam int COUNT_WIDTH  = 32;
    localparam int DATA_WIDTH   = 32;
    localparam int PRE_WIDTH    = 8;
    localparam int DIV_WIDTH    = PRE_WIDTH + 1;
    localparam int ON_BIT       = 15;
    localparam int DIV_SEL_LSB  = 4;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [1:0] REG_CONTROL = 2'd0;
    localparam logic [1:0] REG_COUNT   = 2'd1;
    localparam logic [1:0] REG_PERIOD  = 2'd2;

    localparam logic [1:0] OP_PLAIN  = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_INVERT = 2'd3;

    localparam logic [COUNT_WIDTH-1:0] DEFAULT_PERIOD = COUNT_WIDTH'(16'hFFFF);
    localparam logic [DATA_WIDTH-1:0]  PERIOD_RESET   = DATA_WIDTH'(16'hFFFF);

    typedef struct packed {
        logic [1:0]            cmd;
        logic [1:0]            sel;
        logic [1:0]            op;
        logic [DATA_WIDTH-1:0] data;
    } t_req;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] rdata;
        logic                  rvalid;
        logic                  irq;
    } t_rsp;

    function automatic logic [DATA_WIDTH-1:0] apply_op(
        input logic [DATA_WIDTH-1:0] old_val,
        input logic [DATA_WIDTH-1:0] data,
        input logic [1:0]            op
    );
        logic [DATA_WIDTH-1:0] res;
        unique case (op)
            OP_PLAIN:  res = data;
            OP_CLEAR:  res = old_val & ~data;
            OP_SET:    res = old_val | data;
            OP_INVERT: res = old_val ^ data;
            default:   res = data;
        endcase
        return res;
    endfunction

    function automatic logic [DIV_WIDTH-1:0] divisor(
        input logic       type_a,
        input logic [2:0] sel
    );
        logic [DIV_WIDTH-1:0] d;
        if (type_a) begin
            unique case (sel[1:0])
                2'd0:    d = DIV_WIDTH'(1);
                2'd1:    d = DIV_WIDTH'(8);
                2'd2:    d = DIV_WIDTH'(64);
                2'd3:    d = DIV_WIDTH'(256);
                default: d = DIV_WIDTH'(1);
            endcase
        end else begin
            unique case (sel)
                3'd0:    d = DIV_WIDTH'(1);
                3'd1:    d = DIV_WIDTH'(2);
                3'd2:    d = DIV_WIDTH'(4);
                3'd3:    d = DIV_WIDTH'(8);
                3'd4:    d = DIV_WIDTH'(16);
                3'd5:    d = DIV_WIDTH'(32);
                3'd6:    d = DIV_WIDTH'(64);
                3'd7:    d = DIV_WIDTH'(256);
                default: d = DIV_WIDTH'(1);
            endcase
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- design/prescaled_period_timer_regs_core.sv -----
// ----------------------------------------------------------------------------
// prescaled_period_timer_regs_core
// Prescaled up-counting period timer with control, count and period registers.
// ----------------------------------------------------------------------------
// A word is registered in the input register, then its result in the result
// register. Throughput is one word per cycle while the sink takes each word.
// Reset is synchronous and active low; it empties both pipeline registers,
// clears control, count and prescaler, and loads the period with 65535.
`default_nettype none

module prescaled_period_timer_regs_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,    // type_a_timer
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,     // write_data
    input  wire logic [5:0]  i_s_tuser,     // command, reg_select, sub_op
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,     // read_data
    output logic [1:0]       o_m_tuser      // read_valid, irq_pulse
);
    import ppt_pkg::*;

    t_req in_req;
    t_req st_req;
    t_rsp core_rsp;
    t_rsp out_rsp;
    logic st_valid;
    logic advance;

    assign o_cfg_ready = 1'b1;

    assign in_req.cmd  = i_s_tuser[1:0];
    assign in_req.sel  = i_s_tuser[3:2];
    assign in_req.op   = i_s_tuser[5:4];
    assign in_req.data = i_s_tdata;

    ppt_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_req     (in_req),
        .i_advance (advance),
        .o_valid   (st_valid),
        .o_req     (st_req)
    );

    ppt_timer_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_type_a (i_cfg_data),
        .i_fire       (st_valid && advance),
        .i_req        (st_req),
        .o_rsp        (core_rsp)
    );

    ppt_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (st_valid),
        .i_rsp     (core_rsp),
        .o_advance (advance),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_rsp     (out_rsp)
    );

    assign o_m_tdata = out_rsp.rdata;
    assign o_m_tuser = {out_rsp.irq, out_rsp.rvalid};

endmodule

`default_nettype wire

// ----- design/ppt_in_reg.sv -----
// ----------------------------------------------------------------------------
// ppt_in_reg
// Input register that holds one request word until the timer core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_in_reg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire ppt_pkg::t_req i_req,
    input  wire logic        i_advance,
    output logic             o_valid,
    output ppt_pkg::t_req    o_req
);
    import ppt_pkg::*;

    logic r_valid;
    t_req r_req;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

`default_nettype wire

// ----- design/ppt_timer_core.sv -----
// ----------------------------------------------------------------------------
// ppt_timer_core
// Control, count, period and prescaler registers with the per-word update.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_timer_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_type_a,
    input  wire logic          i_fire,
    input  wire ppt_pkg::t_req i_req,
    output ppt_pkg::t_rsp      o_rsp
);
    import ppt_pkg::*;

    logic                   r_type_a;
    logic [DATA_WIDTH-1:0]  r_ctrl,  n_ctrl;
    logic [COUNT_WIDTH-1:0] r_cnt,   n_cnt;
    logic [DATA_WIDTH-1:0]  r_per,   n_per;
    logic [PRE_WIDTH-1:0]   r_pre,   n_pre;

    logic                   on;
    logic [DIV_WIDTH-1:0]   div;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [COUNT_WIDTH-1:0] eff_per;
    logic [DATA_WIDTH-1:0]  cnt_wr;
    t_rsp                   rsp;

    assign on      = r_ctrl[ON_BIT];
    assign div     = divisor(r_type_a, r_ctrl[DIV_SEL_LSB +: 3]);
    assign cnt_inc = r_cnt + COUNT_WIDTH'(1);
    assign eff_per = (r_per[COUNT_WIDTH-1:0] == '0) ? DEFAULT_PERIOD
                                                    : r_per[COUNT_WIDTH-1:0];
    assign cnt_wr  = apply_op(DATA_WIDTH'(r_cnt), i_req.data, i_req.op);

    always_comb begin
        n_ctrl     = r_ctrl;
        n_cnt      = r_cnt;
        n_per      = r_per;
        n_pre      = r_pre;
        rsp.rdata  = '0;
        rsp.rvalid = 1'b0;
        rsp.irq    = 1'b0;
        unique case (i_req.cmd)
            CMD_TICK: begin
                if (on) begin
                    if ({1'b0, r_pre} + DIV_WIDTH'(1) >= div) begin
                        n_pre = '0;
                        if (cnt_inc == eff_per) begin
                            n_cnt   = '0;
                            rsp.irq = 1'b1;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end else begin
                        n_pre = r_pre + PRE_WIDTH'(1);
                    end
                end
            end
            CMD_READ: begin
                rsp.rvalid = 1'b1;
                unique case (i_req.sel)
                    REG_CONTROL: rsp.rdata = r_ctrl;
                    REG_COUNT:   rsp.rdata = DATA_WIDTH'(r_cnt);
                    REG_PERIOD:  rsp.rdata = r_per;
                    default:     rsp.rdata = '0;
                endcase
            end
            CMD_WRITE: begin
                unique case (i_req.sel)
                    REG_CONTROL: begin
                        n_ctrl = apply_op(r_ctrl, i_req.data, i_req.op);
                        if (n_ctrl[ON_BIT]) begin
                            n_cnt = '0;
                            n_pre = '0;
                        end
                    end
                    REG_COUNT: begin
                        if (!on) begin
                            n_cnt = cnt_wr[COUNT_WIDTH-1:0];
                        end
                    end
                    REG_PERIOD: begin
                        n_per = apply_op(r_per, i_req.data, i_req.op);
                        if (on) begin
                            n_cnt = '0;
                            n_pre = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_rsp = rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_a <= 1'b0;
            r_ctrl   <= '0;
            r_cnt    <= '0;
            r_per    <= PERIOD_RESET;
            r_pre    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_type_a <= i_cfg_type_a;
            end
            if (i_fire) begin
                r_ctrl <= n_ctrl;
                r_cnt  <= n_cnt;
                r_per  <= n_per;
                r_pre  <= n_pre;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/ppt_out_reg.sv -----
// ----------------------------------------------------------------------------
// ppt_out_reg
// Result register that holds one response word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_out_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire ppt_pkg::t_rsp i_rsp,
    output logic               o_advance,
    output logic               o_valid,
    input  wire logic          i_ready,
    output ppt_pkg::t_rsp      o_rsp
);
    import ppt_pkg::*;

    logic r_valid;
    t_rsp r_rsp;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_rsp     = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

`default_nettype wire

// ----- design/ppt_checker.sv -----
// ----------------------------------------------------------------------------
// ppt_checker
// Port-level checks on the timer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic [1:0]  o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("Stalled result word changed.");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("Read answer and interrupt in the same word.");

    a_irq_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 32'd0)
        else $error("Nonzero data on a word that answers no read.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Result valid right after reset.");

endmodule

bind prescaled_period_timer_regs_core ppt_checker u_ppt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives bus words into the prescaled period timer, predicts every result
// word from a local timer model and checks each field under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ppt_pkg::*;

    localparam logic [1:0]  CMD_NOP      = 2'd3;
    localparam logic [1:0]  REG_UNMAPPED = 2'd3;
    localparam logic [31:0] ON_MASK      = 32'd1 << ON_BIT;
    localparam logic [31:0] PERIOD_ZERO_MATCH = 32'h0000_FFFF;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          HOLD_CYCLES  = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [5:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    // Local copy of the timer state.
    logic [31:0]            timer_ctrl = '0;
    logic [COUNT_WIDTH-1:0] timer_count = '0;
    logic [31:0]            timer_period = PERIOD_RESET;
    logic [7:0]             timer_prescale = '0;
    logic                   type_a_mode = 1'b0;

    t_rsp awaited_rsp[$];
    t_rsp want;
    int   err_cnt = 0;
    int   src_idle = 33;
    int   sink_idle = 51;
    int   hold_len = 0;
    int   hold_seq = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    prescaled_period_timer_regs_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] masked_write(input logic [31:0] old_val,
                                                 input logic [31:0] mask,
                                                 input logic [1:0] op);
        case (op)
            OP_CLEAR:  return old_val & ~mask;
            OP_SET:    return old_val | mask;
            OP_INVERT: return old_val ^ mask;
            default:   return mask;
        endcase
    endfunction

    function automatic logic [8:0] prescale_limit();
        logic [2:0] sel;
        sel = timer_ctrl[DIV_SEL_LSB +: 3];
        if (type_a_mode) begin
            case (sel[1:0])
                2'd0:    return 9'd1;
                2'd1:    return 9'd8;
                2'd2:    return 9'd64;
                default: return 9'd256;
            endcase
        end
        if (sel == 3'd7) return 9'd256;
        return 9'd1 << sel;
    endfunction

    function automatic t_rsp timer_step(input t_req rq);
        t_rsp       rsp;
        logic       was_on;
        logic [8:0] limit;
        logic [COUNT_WIDTH-1:0] match;
        rsp = '0;
        was_on = timer_ctrl[ON_BIT];
        case (rq.cmd)
            CMD_TICK: begin
                if (was_on) begin
                    limit = prescale_limit();
                    if ({1'b0, timer_prescale} + 9'd1 >= limit) begin
                        timer_prescale = '0;
                        timer_count = timer_count + 1'b1;
                        match = timer_period[COUNT_WIDTH-1:0];
                        if (match == '0) match = COUNT_WIDTH'(PERIOD_ZERO_MATCH);
                        if (timer_count == match) begin
                            timer_count = '0;
                            rsp.irq = 1'b1;
                        end
                    end else begin
                        timer_prescale = timer_prescale + 8'd1;
                    end
                end
            end
            CMD_READ: begin
                rsp.rvalid = 1'b1;
                case (rq.sel)
                    REG_CONTROL: rsp.rdata = timer_ctrl;
                    REG_COUNT:   rsp.rdata = 32'(timer_count);
                    REG_PERIOD:  rsp.rdata = timer_period;
                    default:     rsp.rdata = '0;
                endcase
            end
            CMD_WRITE: begin
                case (rq.sel)
                    REG_CONTROL: begin
                        timer_ctrl = masked_write(timer_ctrl, rq.data, rq.op);
                        if (timer_ctrl[ON_BIT]) begin
                            timer_count = '0;
                            timer_prescale = '0;
                        end
                    end
                    REG_COUNT: begin
                        if (!was_on) begin
                            timer_count = COUNT_WIDTH'(masked_write(32'(timer_count),
                                                                    rq.data, rq.op));
                        end
                    end
                    REG_PERIOD: begin
                        timer_period = masked_write(timer_period, rq.data, rq.op);
                        if (was_on) begin
                            timer_count = '0;
                            timer_prescale = '0;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic send_word(input logic [1:0] cmd, input logic [1:0] sel,
                             input logic [1:0] op, input logic [31:0] data);
        t_req rq;
        while ($urandom_range(99) < src_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= {op, sel, cmd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        rq.cmd  = cmd;
        rq.sel  = sel;
        rq.op   = op;
        rq.data = data;
        awaited_rsp.push_back(timer_step(rq));
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timer_mode(input logic mode);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        type_a_mode = mode;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_period();
        case ($urandom_range(9))
            0:       return '0;
            1:       return $urandom;
            default: return 32'($urandom_range(6, 1));
        endcase
    endfunction

    task automatic run_random(input int n_words);
        int         sent;
        int         k;
        int         n_ticks;
        logic [2:0] dsel;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(99) < 70) begin
                send_word(CMD_WRITE, REG_PERIOD, OP_PLAIN, pick_period());
                dsel = ($urandom_range(3) == 0) ? 3'($urandom_range(7))
                                                : 3'($urandom_range(1));
                send_word(CMD_WRITE, REG_CONTROL, OP_PLAIN,
                          ($urandom & ~32'h70) | ON_MASK | {25'd0, dsel, 4'd0});
                n_ticks = $urandom_range(20, 4);
                for (k = 0; k < n_ticks; k++) begin
                    case ($urandom_range(19))
                        0, 1: send_word(CMD_READ, 2'($urandom_range(3)),
                                        2'($urandom_range(3)), $urandom);
                        2:    send_word(CMD_WRITE, 2'($urandom_range(3)),
                                        2'($urandom_range(3)), $urandom);
                        default: send_word(CMD_TICK, 2'($urandom_range(3)),
                                           2'($urandom_range(3)), $urandom);
                    endcase
                end
                sent += n_ticks + 2;
            end else begin
                send_word(2'($urandom_range(3)), 2'($urandom_range(3)),
                          2'($urandom_range(3)), $urandom);
                sent++;
            end
        end
    endtask

    task automatic test_reset_values();
        send_word(CMD_READ, REG_CONTROL, OP_PLAIN, '0);
        send_word(CMD_READ, REG_PERIOD, OP_PLAIN, '0);
        send_word(CMD_READ, REG_UNMAPPED, OP_INVERT, '1);
        send_word(CMD_NOP, REG_UNMAPPED, OP_INVERT, '1);
    endtask

    task automatic test_register_ops();
        send_word(CMD_WRITE, REG_COUNT, OP_PLAIN, 32'hFFFF_FFFF);
        send_word(CMD_WRITE, REG_COUNT, OP_CLEAR, 32'h0000_FFFF);
        send_word(CMD_READ, REG_COUNT, OP_PLAIN, '0);
        send_word(CMD_WRITE, REG_PERIOD, OP_INVERT, 32'hFFFF_FFFF);
        send_word(CMD_READ, REG_PERIOD, OP_PLAIN, '0);
        send_word(CMD_WRITE, REG_CONTROL, OP_SET, 32'h0000_0070);
        send_word(CMD_WRITE, REG_UNMAPPED, OP_PLAIN, 32'hFFFF_FFFF);
        send_word(CMD_READ, REG_CONTROL, OP_PLAIN, '0);
    endtask

    task automatic test_run_and_irq();
        send_word(CMD_WRITE, REG_PERIOD, OP_PLAIN, 32'd2);
        send_word(CMD_WRITE, REG_CONTROL, OP_PLAIN, ON_MASK);
        repeat (4) send_word(CMD_TICK, REG_CONTROL, OP_PLAIN, '0);
        send_word(CMD_WRITE, REG_COUNT, OP_PLAIN, 32'd7);
        send_word(CMD_WRITE, REG_PERIOD, OP_PLAIN, 32'd1);
        send_word(CMD_TICK, REG_CONTROL, OP_PLAIN, '0);
        send_word(CMD_WRITE, REG_CONTROL, OP_CLEAR, ON_MASK);
        send_word(CMD_TICK, REG_CONTROL, OP_PLAIN, '0);
        send_word(CMD_READ, REG_COUNT, OP_PLAIN, '0);
    endtask

    // Divide by 16 leaves the prescaler at 3; switching to the type A set
    // makes the divisor 1, so the prescaler is already past its wrap point.
    task automatic test_prescaler_wrap();
        send_word(CMD_WRITE, REG_CONTROL, OP_PLAIN, ON_MASK | 32'h40);
        repeat (3) send_word(CMD_TICK, REG_CONTROL, OP_PLAIN, '0);
        write_timer_mode(1'b1);
        repeat (2) send_word(CMD_TICK, REG_CONTROL, OP_PLAIN, '0);
        send_word(CMD_READ, REG_COUNT, OP_PLAIN, '0);
    endtask

    task automatic test_random_traffic();
        write_timer_mode(1'b0);
        run_random(65);
        write_timer_mode(1'b1);
        run_random(65);
        src_idle = 51;
        sink_idle <= 33;
        write_timer_mode(1'b0);
        run_random(65);
        write_timer_mode(1'b1);
        run_random(65);
        src_idle = 0;
        sink_idle <= 0;
        write_timer_mode(1'($urandom_range(1)));
        run_random(130);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_len <= HOLD_CYCLES;
        hold_seq <= hold_seq + 1;
        run_random(40);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (awaited_rsp.size() == 0) begin
                $error("result word with no expectation: tdata %h tuser %b",
                       o_m_tdata, o_m_tuser);
                err_cnt++;
            end else begin
                want = awaited_rsp.pop_front();
                if (o_m_tdata !== want.rdata) begin
                    $error("read_data: expected %h, got %h", want.rdata, o_m_tdata);
                    err_cnt++;
                end
                if (o_m_tuser[0] !== want.rvalid) begin
                    $error("read_valid: expected %b, got %b", want.rvalid, o_m_tuser[0]);
                    err_cnt++;
                end
                if (o_m_tuser[1] !== want.irq) begin
                    $error("irq_pulse: expected %b, got %b", want.irq, o_m_tuser[1]);
                    err_cnt++;
                end
            end
        end
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_register_ops();
        test_run_and_irq();
        test_prescaler_wrap();
        test_random_traffic();
        test_backpressure();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
design/ppt_pkg.sv
design/ppt_in_reg.sv
design/ppt_timer_core.sv
design/ppt_out_reg.sv
design/prescaled_period_timer_regs_core.sv
design/ppt_checker.sv
tb/tb_top.sv
